FILE: hw/rtl/ihex_pkg.sv
// Shared types, codes and helper functions for the Intel HEX record parser.
// Used by ihex_rec_decode and intel_hex_record_parser; depends on nothing.

package ihex_pkg;

    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPERA = 8'h41;
    localparam logic [7:0] CHAR_UPPERF = 8'h46;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

    localparam logic [7:0] TYPE_DATA      = 8'h00;
    localparam logic [7:0] TYPE_EOF       = 8'h01;
    localparam logic [7:0] TYPE_EXT_LIN   = 8'h04;
    localparam logic [7:0] TYPE_START_LIN = 8'h05;

    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic [7:0]  record_length;
        logic [15:0] load_offset;
        logic [7:0]  record_type;
        logic [1:0]  status;
        logic [15:0] ext_address;
        logic        ext_valid;
    } result_t;

    // Upper-case hex digit to value; anything else decodes as zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                diff = ch - CHAR_ZERO;
            end else if (ch >= CHAR_UPPERA && ch <= CHAR_UPPERF) begin
                diff = ch - CHAR_UPPERA + 8'd10;
            end
            return diff[3:0];
        end
    endfunction

    function automatic logic known_type(input logic [7:0] rtype);
        begin
            return (rtype == TYPE_DATA) || (rtype == TYPE_EOF) ||
                   (rtype == TYPE_EXT_LIN) || (rtype == TYPE_START_LIN);
        end
    endfunction

endpackage

FILE: hw/rtl/ihex_rec_decode.sv
// Record state and per-character decode for the Intel HEX record parser.
// Depends on ihex_pkg for codes, the result struct and the nibble decode.

module ihex_rec_decode
    import ihex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output logic       res_valid,
    output result_t    res
);

    logic        in_record_reg,   in_record_next;
    logic [9:0]  digit_count_reg, digit_count_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  length_reg,      length_next;
    logic [15:0] offset_reg,      offset_next;
    logic [7:0]  type_reg,        type_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] first_two_reg,   first_two_next;

    logic [3:0] nib;
    logic [7:0] data_byte;
    logic [7:0] sum_after;
    logic [8:0] rec_pos;
    logic [8:0] data_pos;
    logic [1:0] close_status;
    logic       ext_ok;

    assign nib       = hex_nibble(char_in);
    assign data_byte = {high_nibble_reg, nib};
    assign sum_after = running_sum_reg + data_byte;
    assign rec_pos   = digit_count_reg[9:1];
    assign data_pos  = rec_pos - 9'd4;

    always_comb
    begin
        if (sum_after != 8'h00) begin
            close_status = STATUS_CSUM_ERR;
        end else if (known_type(type_reg)) begin
            close_status = STATUS_OK;
        end else begin
            close_status = STATUS_BAD_TYPE;
        end
        ext_ok = (close_status == STATUS_OK) && (type_reg == TYPE_EXT_LIN);
    end

    always_comb
    begin
        in_record_next   = in_record_reg;
        digit_count_next = digit_count_reg;
        high_nibble_next = high_nibble_reg;
        length_next      = length_reg;
        offset_next      = offset_reg;
        type_next        = type_reg;
        running_sum_next = running_sum_reg;
        first_two_next   = first_two_reg;
        res_valid        = 1'b0;

        res               = '0;
        res.record_length = length_reg;
        res.load_offset   = offset_reg;
        res.record_type   = type_reg;

        if (!in_record_reg) begin
            if (char_in == CHAR_COLON) begin
                in_record_next   = 1'b1;
                digit_count_next = '0;
                high_nibble_next = '0;
                length_next      = '0;
                offset_next      = '0;
                type_next        = '0;
                running_sum_next = '0;
                first_two_next   = '0;
            end
        end else if (!digit_count_reg[0]) begin
            high_nibble_next = nib;
            digit_count_next = digit_count_reg + 10'd1;
        end else begin
            digit_count_next = digit_count_reg + 10'd1;
            running_sum_next = sum_after;
            if (rec_pos == 9'd0) begin
                length_next = data_byte;
            end else if (rec_pos == 9'd1) begin
                offset_next = {data_byte, 8'h00};
            end else if (rec_pos == 9'd2) begin
                offset_next = {offset_reg[15:8], data_byte};
            end else if (rec_pos == 9'd3) begin
                type_next = data_byte;
            end else if (data_pos < {1'b0, length_reg}) begin
                if (data_pos == 9'd0) begin
                    first_two_next = {data_byte, 8'h00};
                end else if (data_pos == 9'd1) begin
                    first_two_next = {first_two_reg[15:8], data_byte};
                end
                res_valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.byte_value = data_byte;
                res.byte_index = data_pos[7:0];
            end else begin
                // Checksum byte closes the record.
                res_valid        = 1'b1;
                res.kind         = KIND_END;
                res.status       = close_status;
                res.ext_valid    = ext_ok;
                res.ext_address  = ext_ok ? first_two_reg : 16'h0000;
                in_record_next   = 1'b0;
                digit_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_record_reg   <= 1'b0;
            digit_count_reg <= '0;
            high_nibble_reg <= '0;
            length_reg      <= '0;
            offset_reg      <= '0;
            type_reg        <= '0;
            running_sum_reg <= '0;
            first_two_reg   <= '0;
        end else if (step) begin
            in_record_reg   <= in_record_next;
            digit_count_reg <= digit_count_next;
            high_nibble_reg <= high_nibble_next;
            length_reg      <= length_next;
            offset_reg      <= offset_next;
            type_reg        <= type_next;
            running_sum_reg <= running_sum_next;
            first_two_reg   <= first_two_next;
        end
    end

endmodule

FILE: hw/rtl/intel_hex_record_parser.sv
// Intel HEX record parser: an accepted character passes the input register,
// then the result register, on its way to its result on the output.
// Throughput is one character per cycle unless a result stalls on out_ready;
// the output register lets the next request in while a result waits for out_ready.
// Reset (rst_n low, asynchronous) closes any open record, clears the header
// fields and running checksum, and empties both register stages.

module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ascii_char,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  byte_value,
    output logic [7:0]  byte_index,
    output logic [7:0]  record_length,
    output logic [15:0] load_offset,
    output logic [7:0]  record_type,
    output logic [1:0]  status,
    output logic [15:0] ext_address,
    output logic        ext_valid
);

    // Input stage: one character held for decode.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;

    // Result stage.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    in_fire;
    logic    step;
    logic    stall;
    logic    res_valid;
    result_t res;

    // The decode stage only has to wait when it would produce a result and
    // the result register is still occupied by one nobody has taken yet.
    // Characters that produce no result always move through.
    assign stall    = s1_valid_reg && res_valid && out_valid_reg && !out_ready;
    assign step     = s1_valid_reg && !stall;
    assign in_ready = !s1_valid_reg || !stall;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (step) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (step && res_valid) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    ihex_rec_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_in   (s1_char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they are qualified by the valid bits.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_char_reg <= ascii_char;
        end
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign byte_value    = out_reg.byte_value;
    assign byte_index    = out_reg.byte_index;
    assign record_length = out_reg.record_length;
    assign load_offset   = out_reg.load_offset;
    assign record_type   = out_reg.record_type;
    assign status        = out_reg.status;
    assign ext_address   = out_reg.ext_address;
    assign ext_valid     = out_reg.ext_valid;

    // A decoded result is never dropped: it lands in the result register.
    a_result_captured: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> out_valid_reg)
        else $error("decoded result not captured");

    // An extended address only comes with a clean type 04 record end.
    a_ext_only_type04: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ext_valid |->
            kind == KIND_END && status == STATUS_OK && record_type == TYPE_EXT_LIN)
        else $error("ext_valid on a record that is not a good type 04");

    // Data bytes stay inside the length announced by the header.
    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind == KIND_DATA |->
            byte_index < record_length && status == STATUS_OK && !ext_valid)
        else $error("data byte outside record length");

    // A held character is only replaced once it has been decoded.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |-> !in_fire)
        else $error("input stage overwritten while stalled");

endmodule
